### hw/rtl/assert_macros.svh
// assertion helpers used by the gather engine unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tge_pkg.sv
// ----------------------------------------------------------------------------
// tge_pkg
// shared constants, codes and helpers of the tensor gather engine
// ----------------------------------------------------------------------------
`default_nettype none

package tge_pkg;

    localparam int unsigned DATA_DEPTH_DEF  = 4096;
    localparam int unsigned INDEX_DEPTH_DEF = 256;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ADDR_W     = 12;
    localparam int unsigned IDX_W      = 13;
    localparam int unsigned OP_W       = 2;
    localparam int unsigned DIM_W      = 13;
    localparam int unsigned POS_W      = 12;
    localparam int unsigned NCFG_W     = 9;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned MAX_DIM    = 4096;

    typedef enum logic [OP_W-1:0] {
        OP_WR_DATA  = 2'd0,
        OP_WR_INDEX = 2'd1,
        OP_EMIT     = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTER_COUNT = 2'd0,
        CFG_AXIS_LEN    = 2'd1,
        CFG_INNER_COUNT = 2'd2,
        CFG_INDEX_COUNT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_ADDR,
        ST_READ,
        ST_DONE
    } t_state;

    // zero counts as one, anything above the largest dimension saturates
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/tge_walk.sv
// ----------------------------------------------------------------------------
// tge_walk
// nested outer / index / inner position counters of the gather pass
// ----------------------------------------------------------------------------
`default_nettype none

module tge_walk #(
    parameter int unsigned INDEX_DEPTH = tge_pkg::INDEX_DEPTH_DEF,
    localparam int unsigned IW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1,
    localparam int unsigned CW = IW + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_restart,
    input  logic                       i_advance,
    input  logic [tge_pkg::DIM_W-1:0]  i_outer_cnt,
    input  logic [tge_pkg::DIM_W-1:0]  i_inner_cnt,
    input  logic [CW-1:0]              i_index_cnt,
    output logic [tge_pkg::POS_W-1:0]  o_outer_pos,
    output logic [IW-1:0]              o_index_pos,
    output logic [tge_pkg::POS_W-1:0]  o_inner_pos,
    output logic                       o_last
);

    logic [tge_pkg::POS_W-1:0] r_outer_pos, n_outer_pos;
    logic [IW-1:0]             r_index_pos, n_index_pos;
    logic [tge_pkg::POS_W-1:0] r_inner_pos, n_inner_pos;

    logic [tge_pkg::DIM_W-1:0] w_outer_inc;
    logic [tge_pkg::DIM_W-1:0] w_inner_inc;
    logic [CW-1:0]             w_index_inc;
    logic                      w_outer_wrap;
    logic                      w_index_wrap;
    logic                      w_inner_wrap;

    assign w_outer_inc = {1'b0, r_outer_pos} + tge_pkg::DIM_W'(1);
    assign w_inner_inc = {1'b0, r_inner_pos} + tge_pkg::DIM_W'(1);
    assign w_index_inc = {1'b0, r_index_pos} + CW'(1);

    // a position whose successor reaches or passes its count wraps, which also covers counts shrunk mid-pass
    assign w_outer_wrap = (w_outer_inc >= i_outer_cnt);
    assign w_index_wrap = (w_index_inc >= i_index_cnt);
    assign w_inner_wrap = (w_inner_inc >= i_inner_cnt);

    assign o_last = w_outer_wrap && w_index_wrap && w_inner_wrap;

    always_comb begin
        n_outer_pos = r_outer_pos;
        n_index_pos = r_index_pos;
        n_inner_pos = r_inner_pos;
        if (i_restart || (i_advance && o_last)) begin
            n_outer_pos = '0;
            n_index_pos = '0;
            n_inner_pos = '0;
        end else if (i_advance) begin
            if (!w_inner_wrap) begin
                n_inner_pos = w_inner_inc[tge_pkg::POS_W-1:0];
            end else begin
                n_inner_pos = '0;
                if (!w_index_wrap) begin
                    n_index_pos = w_index_inc[IW-1:0];
                end else begin
                    n_index_pos = '0;
                    n_outer_pos = w_outer_wrap ? '0 : w_outer_inc[tge_pkg::POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_pos <= '0;
            r_index_pos <= '0;
            r_inner_pos <= '0;
        end else begin
            r_outer_pos <= n_outer_pos;
            r_index_pos <= n_index_pos;
            r_inner_pos <= n_inner_pos;
        end
    end

    assign o_outer_pos = r_outer_pos;
    assign o_index_pos = r_index_pos;
    assign o_inner_pos = r_inner_pos;

endmodule

`default_nettype wire

### hw/rtl/tensor_gather_engine_unit.sv
// ----------------------------------------------------------------------------
// tensor_gather_engine_unit: gather along one tensor axis
// write beats are accepted whenever the engine is idle; an emit beat stalls the
// input until its result is loaded into the output register, so beats never overlap;
// it passes through index read, two multiply stages and the data read in sequence
// reset clears the walk counters and sets all counts to 1; no store clearing
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tensor_gather_engine_unit #(
    parameter int unsigned DATA_DEPTH  = tge_pkg::DATA_DEPTH_DEF,
    parameter int unsigned INDEX_DEPTH = tge_pkg::INDEX_DEPTH_DEF,
    localparam int unsigned DW = $clog2(DATA_DEPTH),
    localparam int unsigned IW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1,
    localparam int unsigned CW = IW + 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beats
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tge_pkg::OP_W-1:0]          i_op,
    input  logic [tge_pkg::ADDR_W-1:0]        i_addr,
    input  logic [tge_pkg::WORD_W-1:0]        i_data_word,
    input  logic signed [tge_pkg::IDX_W-1:0]  i_index_value,
    // result beats
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tge_pkg::WORD_W-1:0]        o_out_word,
    output logic                              o_last,
    output logic                              o_error,
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [tge_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tge_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned XW0 = (DW > tge_pkg::ADDR_W) ? DW : tge_pkg::ADDR_W;
    localparam int unsigned XW  = (IW > XW0) ? IW : XW0;
    localparam int unsigned PROD1_W = tge_pkg::POS_W + tge_pkg::DIM_W;
    localparam int unsigned SUM_W   = PROD1_W + 1;
    localparam int unsigned PROD2_W = SUM_W + tge_pkg::DIM_W;
    localparam int unsigned FA_W    = PROD2_W + 1;

    // count registers, stored already clamped
    logic [tge_pkg::DIM_W-1:0] r_outer_cnt;
    logic [tge_pkg::DIM_W-1:0] r_axis_len;
    logic [tge_pkg::DIM_W-1:0] r_inner_cnt;
    logic [CW-1:0]             r_index_cnt;
    logic [31:0]               w_ncfg;
    logic [31:0]               w_ncfg_clamped;

    tge_pkg::t_state r_state, n_state;
    tge_pkg::t_op    w_op;

    logic                      w_in_acc;
    logic                      w_emit_acc;
    logic                      w_restart;
    logic                      w_wr_data;
    logic                      w_wr_index;
    logic                      w_load_out;
    logic                      w_rd_data;
    logic [XW-1:0]             w_addr_wide;

    // stores
    logic [tge_pkg::WORD_W-1:0] r_data_mem  [DATA_DEPTH];
    logic [tge_pkg::IDX_W-1:0]  r_index_mem [INDEX_DEPTH];
    logic [tge_pkg::WORD_W-1:0] r_data_rd;
    logic [tge_pkg::IDX_W-1:0]  r_index_rd;

    // walk
    logic [tge_pkg::POS_W-1:0] w_outer_pos;
    logic [IW-1:0]             w_index_pos;
    logic [tge_pkg::POS_W-1:0] w_inner_pos;
    logic                      w_walk_last;

    // per-beat working registers
    logic [tge_pkg::POS_W-1:0] r_op_outer;
    logic [tge_pkg::POS_W-1:0] r_op_inner;
    logic                      r_op_last;
    logic [tge_pkg::IDX_W:0]   w_g_ext;
    logic                      w_g_err;
    logic [PROD1_W-1:0]        w_prod1;
    logic [PROD1_W-1:0]        r_prod1;
    logic [tge_pkg::DIM_W-1:0] r_g;
    logic                      r_g_err;
    logic [SUM_W-1:0]          w_sum;
    logic [PROD2_W-1:0]        w_prod2;
    logic [FA_W-1:0]           r_addr;
    logic                      r_err;

    // output register
    logic                       r_out_valid;
    logic [tge_pkg::WORD_W-1:0] r_out_word;
    logic                       r_out_last;
    logic                       r_out_err;

    assign w_op        = tge_pkg::t_op'(i_op);
    assign w_addr_wide = XW'(i_addr);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_emit_acc  = w_in_acc && (w_op == tge_pkg::OP_EMIT);
    assign w_restart   = w_in_acc
                         && ((w_op == tge_pkg::OP_WR_DATA) || (w_op == tge_pkg::OP_WR_INDEX));
    // out-of-range writes are dropped but still restart the walk
    assign w_wr_data   = w_in_acc && (w_op == tge_pkg::OP_WR_DATA)
                         && (32'(i_addr) < DATA_DEPTH);
    assign w_wr_index  = w_in_acc && (w_op == tge_pkg::OP_WR_INDEX)
                         && (32'(i_addr) < INDEX_DEPTH);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign w_ncfg = 32'(i_cfg_data[tge_pkg::NCFG_W-1:0]);

    always_comb begin
        if (w_ncfg == 32'd0) begin
            w_ncfg_clamped = 32'd1;
        end else if (w_ncfg > INDEX_DEPTH) begin
            w_ncfg_clamped = INDEX_DEPTH;
        end else begin
            w_ncfg_clamped = w_ncfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer_cnt <= tge_pkg::DIM_W'(1);
            r_axis_len  <= tge_pkg::DIM_W'(1);
            r_inner_cnt <= tge_pkg::DIM_W'(1);
            r_index_cnt <= CW'(1);
        end else if (i_cfg_we) begin
            unique case (tge_pkg::t_cfg_idx'(i_cfg_index))
                tge_pkg::CFG_OUTER_COUNT: r_outer_cnt <= tge_pkg::clamp_dim(i_cfg_data);
                tge_pkg::CFG_AXIS_LEN:    r_axis_len  <= tge_pkg::clamp_dim(i_cfg_data);
                tge_pkg::CFG_INNER_COUNT: r_inner_cnt <= tge_pkg::clamp_dim(i_cfg_data);
                tge_pkg::CFG_INDEX_COUNT: r_index_cnt <= w_ncfg_clamped[CW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // walk counters
    // ------------------------------------------------------------------
    tge_walk #(
        .INDEX_DEPTH (INDEX_DEPTH)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_restart),
        .i_advance   (w_emit_acc),
        .i_outer_cnt (r_outer_cnt),
        .i_inner_cnt (r_inner_cnt),
        .i_index_cnt (r_index_cnt),
        .o_outer_pos (w_outer_pos),
        .o_index_pos (w_index_pos),
        .o_inner_pos (w_inner_pos),
        .o_last      (w_walk_last)
    );

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tge_pkg::ST_IDLE:  if (w_emit_acc) n_state = tge_pkg::ST_INDEX;
            tge_pkg::ST_INDEX: n_state = tge_pkg::ST_ADDR;
            tge_pkg::ST_ADDR:  n_state = tge_pkg::ST_READ;
            tge_pkg::ST_READ:  n_state = tge_pkg::ST_DONE;
            tge_pkg::ST_DONE:  if (w_load_out) n_state = tge_pkg::ST_IDLE;
            default:           n_state = tge_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != tge_pkg::ST_IDLE);
        w_rd_data  = (r_state == tge_pkg::ST_READ);
        // result moves on once the output register is empty or being drained
        w_load_out = (r_state == tge_pkg::ST_DONE) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tge_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // stores, one write and one registered read each
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_wr_data) begin
            r_data_mem[w_addr_wide[DW-1:0]] <= i_data_word;
        end
        if (w_rd_data) begin
            r_data_rd <= r_data_mem[r_addr[DW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_index) begin
            r_index_mem[w_addr_wide[IW-1:0]] <= i_index_value;
        end
        if (w_emit_acc) begin
            r_index_rd <= r_index_mem[w_index_pos];
        end
    end

    // ------------------------------------------------------------------
    // address path
    // ------------------------------------------------------------------
    // negative index gets the axis length added once
    assign w_g_ext = {r_index_rd[tge_pkg::IDX_W-1], r_index_rd}
                     + (r_index_rd[tge_pkg::IDX_W-1] ? {1'b0, r_axis_len}
                                                     : (tge_pkg::IDX_W + 1)'(0));
    assign w_g_err = w_g_ext[tge_pkg::IDX_W]
                     || (w_g_ext[tge_pkg::IDX_W-1:0] >= r_axis_len);
    assign w_prod1 = r_op_outer * r_axis_len;
    assign w_sum   = SUM_W'(r_prod1) + SUM_W'(r_g);
    assign w_prod2 = w_sum * r_inner_cnt;

    always_ff @(posedge i_clk) begin
        if (w_emit_acc) begin
            r_op_outer <= w_outer_pos;
            r_op_inner <= w_inner_pos;
            r_op_last  <= w_walk_last;
        end
        if (r_state == tge_pkg::ST_INDEX) begin
            r_g     <= w_g_ext[tge_pkg::IDX_W-1:0];
            r_g_err <= w_g_err;
            r_prod1 <= w_prod1;
        end
        if (r_state == tge_pkg::ST_ADDR) begin
            r_addr <= FA_W'(w_prod2) + FA_W'(r_op_inner);
        end
        if (r_state == tge_pkg::ST_READ) begin
            r_err <= r_g_err || (r_addr >= FA_W'(DATA_DEPTH));
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_word <= r_err ? '0 : r_data_rd;
            r_out_last <= r_op_last;
            r_out_err  <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_last      = r_out_last;
    assign o_error     = r_out_err;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_IMP(a_err_zero_word, i_clk, i_rst_n, o_out_valid && o_error, o_out_word == '0, "error beat carries a nonzero word")
    `ASSERT_NXT(a_write_restart, i_clk, i_rst_n, w_restart, (w_outer_pos == '0) && (w_index_pos == '0) && (w_inner_pos == '0), "walk not restarted after a store write")
    `ASSERT_NXT(a_last_restart, i_clk, i_rst_n, w_emit_acc && w_walk_last, (w_outer_pos == '0) && (w_index_pos == '0) && (w_inner_pos == '0), "walk not restarted after last element")
    `ASSERT_NXT(a_load_free, i_clk, i_rst_n, w_load_out, o_out_valid && (r_state == tge_pkg::ST_IDLE), "result load did not free the engine")

endmodule

`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: tensor gather engine regression
// loads the data and index stores, walks gather passes under a range of axis
// shapes and handshake pressure, and checks every result beat against a directed
// expectation or an in-bench model of the gather walk
// ----------------------------------------------------------------------------

module testbench;

    import tge_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 1000000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned MISS_PRINTS  = 100;
    localparam int unsigned FILL_DATA    = 512;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              err;
    } gather_res_t;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  idx;
        bit                typed;
        gather_res_t       want;
    } stim_row_t;

    // all counts are 1 here, so each gather is a one-element pass
    localparam stim_row_t DIRECTED_ROWS [20] = '{
        '{OP_WR_DATA,  12'h000, 32'hFFFF_FFFF, 13'h0000, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_WR_INDEX, 12'h000, 32'h0000_0000, 13'h0000, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_EMIT,     12'h000, 32'h0000_0000, 13'h0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
        // minus one wraps to zero
        '{OP_WR_INDEX, 12'h000, 32'h0000_0000, 13'h1FFF, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_EMIT,     12'h000, 32'h0000_0000, 13'h0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
        // most negative index stays negative after the wrap
        '{OP_WR_INDEX, 12'h000, 32'h0000_0000, 13'h1000, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_EMIT,     12'h000, 32'h0000_0000, 13'h0000, 1'b1, '{32'h0, 1'b1, 1'b1}},
        '{OP_WR_INDEX, 12'h000, 32'h0000_0000, 13'h0FFF, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_EMIT,     12'h000, 32'h0000_0000, 13'h0000, 1'b1, '{32'h0, 1'b1, 1'b1}},
        // index write past the store is dropped
        '{OP_WR_INDEX, 12'hFFF, 32'h0000_0000, 13'h0000, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_EMIT,     12'h000, 32'h0000_0000, 13'h0000, 1'b1, '{32'h0, 1'b1, 1'b1}},
        '{OP_NONE,     12'hFFF, 32'hFFFF_FFFF, 13'h1FFF, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_WR_DATA,  12'hFFF, 32'h0000_0000, 13'h0000, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_WR_DATA,  12'h000, 32'h0000_0000, 13'h0000, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_WR_INDEX, 12'h0FF, 32'h0000_0000, 13'h1000, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_WR_INDEX, 12'h000, 32'h0000_0000, 13'h0000, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_EMIT,     12'h000, 32'h0000_0000, 13'h0000, 1'b1, '{32'h0, 1'b1, 1'b0}},
        '{OP_WR_DATA,  12'h000, 32'h5A5A_A5A5, 13'h0000, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_EMIT,     12'h000, 32'h0000_0000, 13'h0000, 1'b0, '{32'h0, 1'b0, 1'b0}},
        '{OP_EMIT,     12'hFFF, 32'hFFFF_FFFF, 13'h1FFF, 1'b0, '{32'h0, 1'b0, 1'b0}}
    };

    // outer, axis, inner, index count
    localparam logic [CFG_DATA_W-1:0] EXTREME_SHAPES [4][4] = '{
        '{13'd0,    13'd0,    13'd0,    13'd0},
        '{13'd8191, 13'd8191, 13'd8191, 13'd8191},
        '{13'd2,    13'd4096, 13'd1,    13'd1},
        '{13'd1,    13'd1,    13'd4096, 13'd256}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    t_op                     in_op = OP_NONE;
    logic [ADDR_W-1:0]       in_addr = '0;
    logic [WORD_W-1:0]       in_word = '0;
    logic signed [IDX_W-1:0] in_index = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [WORD_W-1:0]       out_word;
    logic                    out_last;
    logic                    out_error;
    logic                    cfg_we = 1'b0;
    t_cfg_idx                cfg_index = CFG_OUTER_COUNT;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // model of the gather walk
    logic [WORD_W-1:0]       data_mem [DATA_DEPTH_DEF];
    logic signed [IDX_W-1:0] index_mem [INDEX_DEPTH_DEF];
    bit                      data_known [DATA_DEPTH_DEF];
    bit                      index_known [INDEX_DEPTH_DEF];
    logic [CFG_DATA_W-1:0]   shape_outer = 13'd1;
    logic [CFG_DATA_W-1:0]   shape_axis = 13'd1;
    logic [CFG_DATA_W-1:0]   shape_inner = 13'd1;
    logic [NCFG_W-1:0]       shape_nidx = 9'd1;
    int unsigned             walk_outer = 0;
    int unsigned             walk_index = 0;
    int unsigned             walk_inner = 0;

    gather_res_t             gathered_q [$];

    int unsigned             send_idle_pct = 0;
    int unsigned             recv_idle_pct = 0;
    int unsigned             hold_asked = 0;
    int unsigned             hold_served = 0;
    int unsigned             hold_left = 0;
    int unsigned             cycle_count = 0;
    int unsigned             beats_sent = 0;
    int unsigned             shapes_set = 0;
    int unsigned             words_checked = 0;
    int unsigned             words_flagged = 0;
    int unsigned             pass_ends = 0;
    int unsigned             mismatches = 0;

    tensor_gather_engine_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_op          (in_op),
        .i_addr        (in_addr),
        .i_data_word   (in_word),
        .i_index_value (in_index),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_word    (out_word),
        .o_last        (out_last),
        .o_error       (out_error),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t ns: no progress, run stopped", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int unsigned eff_count(input logic [CFG_DATA_W-1:0] v,
                                              input int unsigned hi);
        int unsigned res;
        res = v;
        if (res == 0) begin
            res = 1;
        end else if (res > hi) begin
            res = hi;
        end
        return res;
    endfunction

    function automatic void gather_addr(output bit ok, output longint a);
        int          g;
        int unsigned al;
        int unsigned ic;
        al = eff_count(shape_axis, MAX_DIM);
        ic = eff_count(shape_inner, MAX_DIM);
        g = index_mem[walk_index];
        if (g < 0) begin
            g = g + int'(al);
        end
        ok = (g >= 0) && (g < int'(al));
        a = (longint'(walk_outer) * longint'(al) + longint'(g)) * longint'(ic)
            + longint'(walk_inner);
    endfunction

    function automatic void restart_walk();
        walk_outer = 0;
        walk_index = 0;
        walk_inner = 0;
    endfunction

    // next gathered word, then step the walk
    function automatic gather_res_t predict_gather();
        gather_res_t res;
        bit          ok;
        longint      a;
        int unsigned oc;
        int unsigned ic;
        int unsigned nc;
        oc = eff_count(shape_outer, MAX_DIM);
        ic = eff_count(shape_inner, MAX_DIM);
        nc = eff_count(CFG_DATA_W'(shape_nidx), INDEX_DEPTH_DEF);
        gather_addr(ok, a);
        res.word = '0;
        res.err = 1'b0;
        if (ok && a < longint'(DATA_DEPTH_DEF)) begin
            res.word = data_mem[int'(a)];
        end else begin
            res.err = 1'b1;
        end
        res.last = (walk_inner + 1 >= ic) && (walk_index + 1 >= nc)
                   && (walk_outer + 1 >= oc);
        if (res.last) begin
            restart_walk();
        end else begin
            walk_inner++;
            if (walk_inner >= ic) begin
                walk_inner = 0;
                walk_index++;
                if (walk_index >= nc) begin
                    walk_index = 0;
                    walk_outer++;
                    if (walk_outer >= oc) begin
                        walk_outer = 0;
                    end
                end
            end
        end
        return res;
    endfunction

    // store entry that the next gather would read before it was ever written
    function automatic bit unread_entry(output t_op fix_op, output int unsigned fix_addr);
        bit     ok;
        longint a;
        fix_op = OP_NONE;
        fix_addr = 0;
        if (!index_known[walk_index]) begin
            fix_op = OP_WR_INDEX;
            fix_addr = walk_index;
            return 1'b1;
        end
        gather_addr(ok, a);
        if (ok && a < longint'(DATA_DEPTH_DEF) && !data_known[int'(a)]) begin
            fix_op = OP_WR_DATA;
            fix_addr = int'(a);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic signed [IDX_W-1:0] rand_index(input int unsigned al);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75) begin
            return IDX_W'(int'($urandom_range(2 * al - 1)) - int'(al));
        end else if (r < 92) begin
            return IDX_W'($urandom);
        end
        return ($urandom_range(1) != 0) ? 13'sh0FFF : 13'sh1000;
    endfunction

    task automatic send_beat(input t_op op, input logic [ADDR_W-1:0] addr,
                             input logic [WORD_W-1:0] word, input logic [IDX_W-1:0] idx,
                             input bit typed, input gather_res_t want);
        gather_res_t res;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_addr <= addr;
        in_word <= word;
        in_index <= idx;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        case (op)
            OP_WR_DATA: begin
                data_mem[addr] = word;
                data_known[addr] = 1'b1;
                restart_walk();
            end
            OP_WR_INDEX: begin
                if (addr < INDEX_DEPTH_DEF) begin
                    index_mem[addr] = idx;
                    index_known[addr] = 1'b1;
                end
                restart_walk();
            end
            OP_EMIT: begin
                res = predict_gather();
                gathered_q.push_back(typed ? want : res);
            end
            default: ;
        endcase
        if (op != OP_NONE) begin
            beats_sent++;
        end
    endtask

    task automatic emit_run(input int unsigned n);
        t_op         fix_op;
        int unsigned fix_addr;
        repeat (n) begin
            // back-fill anything the walk is about to read for the first time
            while (unread_entry(fix_op, fix_addr)) begin
                send_beat(fix_op, ADDR_W'(fix_addr), $urandom,
                          rand_index(eff_count(shape_axis, MAX_DIM)), 1'b0, '0);
            end
            send_beat(OP_EMIT, ADDR_W'($urandom), $urandom, IDX_W'($urandom), 1'b0, '0);
        end
    endtask

    // wait for every result, then give the engine time to finish any write
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (gathered_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            CFG_OUTER_COUNT: shape_outer = v;
            CFG_AXIS_LEN:    shape_axis = v;
            CFG_INNER_COUNT: shape_inner = v;
            CFG_INDEX_COUNT: shape_nidx = v[NCFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_shape(input logic [CFG_DATA_W-1:0] oc,
                                 input logic [CFG_DATA_W-1:0] al,
                                 input logic [CFG_DATA_W-1:0] ic,
                                 input logic [CFG_DATA_W-1:0] nc);
        write_reg(CFG_OUTER_COUNT, oc);
        write_reg(CFG_AXIS_LEN, al);
        write_reg(CFG_INNER_COUNT, ic);
        write_reg(CFG_INDEX_COUNT, nc);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        shapes_set++;
    endtask

    task automatic run_episode(input bit big);
        int unsigned al;
        int unsigned nc;
        int unsigned cap;
        int unsigned r;
        longint      pass;
        al = eff_count(shape_axis, MAX_DIM);
        nc = eff_count(CFG_DATA_W'(shape_nidx), INDEX_DEPTH_DEF);
        pass = longint'(eff_count(shape_outer, MAX_DIM)) * nc
               * eff_count(shape_inner, MAX_DIM);
        cap = big ? 40 : 80;
        if (pass < cap) begin
            cap = int'(pass);
        end
        r = $urandom_range(99);
        if (r < 70) begin
            // any fresh index write restarts the walk before the run
            repeat ($urandom_range(2)) begin
                send_beat(OP_WR_INDEX, ADDR_W'($urandom_range(nc - 1)), $urandom,
                          rand_index(al), 1'b0, '0);
            end
            if ($urandom_range(4) == 0) begin
                send_beat(OP_WR_DATA, ADDR_W'($urandom_range(FILL_DATA - 1)), $urandom,
                          IDX_W'($urandom), 1'b0, '0);
            end
            emit_run(cap + $urandom_range(3));
        end else if (r < 88) begin
            // pass cut short by a dropped write
            emit_run($urandom_range(cap, 1));
            send_beat(OP_WR_INDEX, ADDR_W'($urandom_range(4095, INDEX_DEPTH_DEF)), $urandom,
                      IDX_W'($urandom), 1'b0, '0);
        end else begin
            repeat ($urandom_range(3, 1)) begin
                send_beat(OP_NONE, ADDR_W'($urandom), $urandom, IDX_W'($urandom), 1'b0, '0);
            end
            emit_run($urandom_range(6, 1));
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic report_miss(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        mismatches++;
        if (mismatches <= MISS_PRINTS) begin
            $display("%0t ns: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        gather_res_t want;
        if (i_rst_n && out_valid === 1'b1 && !out_stall) begin
            if (gathered_q.size() == 0) begin
                report_miss("result beat with nothing pending, out_word", '0, out_word);
            end else begin
                want = gathered_q.pop_front();
                words_checked++;
                if (out_error === 1'b1) begin
                    words_flagged++;
                end
                if (out_last === 1'b1) begin
                    pass_ends++;
                end
                if (out_word !== want.word) begin
                    report_miss("out_word", want.word, out_word);
                end
                if (out_last !== want.last) begin
                    report_miss("last", WORD_W'(want.last), WORD_W'(out_last));
                end
                if (out_error !== want.err) begin
                    report_miss("error", WORD_W'(want.err), WORD_W'(out_error));
                end
            end
        end
    end

    initial begin
        int unsigned phase_end;
        int unsigned shape_end;
        int unsigned k;
        bit          first;
        bit          big;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            send_beat(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].addr, DIRECTED_ROWS[i].word,
                      DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end

        // load every index and the low part of the data store
        for (int a = 0; a < INDEX_DEPTH_DEF; a++) begin
            send_beat(OP_WR_INDEX, ADDR_W'(a), $urandom,
                      IDX_W'(int'($urandom_range(15)) - 8), 1'b0, '0);
        end
        for (int a = 0; a < FILL_DATA; a++) begin
            send_beat(OP_WR_DATA, ADDR_W'(a), $urandom, IDX_W'($urandom), 1'b0, '0);
        end

        // receiver holds off while gathers keep coming, so the input backs up
        settle();
        program_shape(13'd3, 13'd4, 13'd4, 13'd5);
        hold_asked++;
        emit_run(90);

        for (int m = 0; m < 4; m++) begin
            case (m)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 86; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 86; end
                default: begin send_idle_pct = 26; recv_idle_pct = 26; end
            endcase
            phase_end = beats_sent + 450;
            first = 1'b1;
            while (beats_sent < phase_end) begin
                settle();
                big = first || ($urandom_range(9) == 0);
                if (big) begin
                    k = first ? m : $urandom_range(3);
                    program_shape(EXTREME_SHAPES[k][0], EXTREME_SHAPES[k][1],
                                  EXTREME_SHAPES[k][2], EXTREME_SHAPES[k][3]);
                end else begin
                    program_shape(CFG_DATA_W'($urandom_range(3)),
                                  CFG_DATA_W'($urandom_range(8, 1)),
                                  CFG_DATA_W'($urandom_range(4)),
                                  CFG_DATA_W'($urandom_range(6)));
                end
                first = 1'b0;
                shape_end = beats_sent + $urandom_range(140, 60);
                while (beats_sent < shape_end) begin
                    run_episode(big);
                end
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        $display("covered %0d beats over %0d axis shapes, all four idling mixes",
                 beats_sent, shapes_set);
        $display("checked %0d gathered words: %0d flagged out of range, %0d pass ends",
                 words_checked, words_flagged, pass_ends);
        if (mismatches == 0 && gathered_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
